// ===== sv/ptlru_pkg.sv =====
// Shared constants and types for the per-thread LRU slot table.
`default_nettype none

package ptlru_pkg;

    // Width of a requester (thread) identifier.
    localparam int ID_W = 31;

    // Width of the slot index field on the result channel.
    localparam int IDX_W = 4;

    // Default number of table slots.
    localparam int SLOTS_DEF = 10;

    // Requester identifier type.
    typedef logic [ID_W-1:0] t_id;

endpackage : ptlru_pkg

`default_nettype wire

// ===== sv/ptlru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ptlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : ptlru_ram

`default_nettype wire

// ===== sv/per_thread_lru_slot_table_core.sv =====
// Top level of the per-thread LRU slot table: sequencer, recency ages and owner RAM.
//
// A request transaction carries a requester id on i_requester_id under
// i_req_valid / o_req_ready. Each request gives exactly one response
// transaction on o_slot_index, o_hit and o_evicted under o_rsp_valid /
// i_rsp_ready, in request order.
// The owner ids live in a RAM and are searched one slot at a time by a
// single comparator: the read state issues the read, the compare state
// compares the data and checks whether that slot is the least recently
// used one. A hit ends the search early, and when the table is empty the
// search is skipped. The block accepts a new request once the previous one
// has passed its update step.
// Recency is held as one age per slot (0 = most recently used), updated for
// all slots in parallel in the update step.
// After reset no slot is in use; the owner RAM needs no clearing pass.
// When the receiver stalls, the response is held in the output register;
// the next request may be searched meanwhile but waits before its update.
`default_nettype none

module per_thread_lru_slot_table_core #(
    parameter int SLOTS = ptlru_pkg::SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [ptlru_pkg::ID_W-1:0] i_requester_id,
    output logic                            o_rsp_valid,
    input  wire logic                       i_rsp_ready,
    output logic [ptlru_pkg::IDX_W-1:0]     o_slot_index,
    output logic                            o_hit,
    output logic                            o_evicted
);

    import ptlru_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LRU_AGE  = SLOT_W'(SLOTS - 1);

    // Sequencer state codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [SLOT_W-1:0] r_scan, n_scan;
    logic [SLOT_W-1:0] r_victim, n_victim;
    logic [SLOT_W-1:0] r_hit_slot, n_hit_slot;
    logic [SLOT_W-1:0] r_hit_age, n_hit_age;
    logic              r_found, n_found;
    t_id               r_id, n_id;
    logic [SLOT_W-1:0] r_age [SLOTS];

    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_hit, n_out_hit;
    logic              r_out_evict, n_out_evict;

    t_id               ram_rdata;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;

    logic              upd_go;
    logic              is_full;
    logic [SLOT_W-1:0] upd_slot;
    logic [CNT_W-1:0]  upd_ref;
    logic              last_scan;

    // Owner id storage.
    ptlru_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_raddr (r_scan),
        .o_rdata (ram_rdata)
    );

    assign is_full   = (r_used == FULL_CNT);
    assign last_scan = ((CNT_W'(r_scan) + CNT_W'(1)) == r_used);
    assign upd_go    = (r_state == ST_UPD) && (!r_out_valid || i_rsp_ready);

    // Slot taken and age threshold for the update step: on a hit only younger
    // slots age, on a fill every used slot ages, on an eviction all others age.
    always_comb begin
        if (r_found) begin
            upd_slot = r_hit_slot;
            upd_ref  = CNT_W'(r_hit_age);
        end else if (!is_full) begin
            upd_slot = SLOT_W'(r_used);
            upd_ref  = FULL_CNT;
        end else begin
            upd_slot = r_victim;
            upd_ref  = CNT_W'(LRU_AGE);
        end
    end

    assign ram_we    = upd_go && !r_found;
    assign ram_waddr = upd_slot;

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_scan      = r_scan;
        n_victim    = r_victim;
        n_hit_slot  = r_hit_slot;
        n_hit_age   = r_hit_age;
        n_found     = r_found;
        n_id        = r_id;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out_slot  = r_out_slot;
        n_out_hit   = r_out_hit;
        n_out_evict = r_out_evict;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_id    = i_requester_id;
                    n_scan  = '0;
                    n_found = 1'b0;
                    n_state = (r_used == '0) ? ST_UPD : ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_age[r_scan] == LRU_AGE) begin
                    n_victim = r_scan;
                end
                if (ram_rdata == r_id) begin
                    n_found    = 1'b1;
                    n_hit_slot = r_scan;
                    n_hit_age  = r_age[r_scan];
                    n_state    = ST_UPD;
                end else if (last_scan) begin
                    n_state = ST_UPD;
                end else begin
                    n_scan  = r_scan + SLOT_W'(1);
                    n_state = ST_RD;
                end
            end
            ST_UPD: begin
                if (upd_go) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = upd_slot;
                    n_out_hit   = r_found;
                    n_out_evict = !r_found && is_full;
                    if (!r_found && !is_full) begin
                        n_used = r_used + CNT_W'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and response payload registers.
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_victim    <= n_victim;
        r_hit_slot  <= n_hit_slot;
        r_hit_age   <= n_hit_age;
        r_found     <= n_found;
        r_id        <= n_id;
        r_out_slot  <= n_out_slot;
        r_out_hit   <= n_out_hit;
        r_out_evict <= n_out_evict;
    end

    // Recency ages: the taken slot becomes youngest, used slots below the
    // threshold grow one older.
    for (genvar k = 0; k < SLOTS; k++) begin : g_age
        always_ff @(posedge i_clk) begin
            if (upd_go) begin
                if (upd_slot == SLOT_W'(k)) begin
                    r_age[k] <= '0;
                end else if ((CNT_W'(k) < r_used) && (CNT_W'(r_age[k]) < upd_ref)) begin
                    r_age[k] <= r_age[k] + SLOT_W'(1);
                end
            end
        end
    end

    assign o_req_ready  = (r_state == ST_IDLE);
    assign o_rsp_valid  = r_out_valid;
    assign o_slot_index = IDX_W'(r_out_slot);
    assign o_hit        = r_out_hit;
    assign o_evicted    = r_out_evict;

    // The fill count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("slot fill count exceeds table size");

    // A response is never both a hit and an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_hit && o_evicted))
        else $error("response flags both hit and eviction");

    // An eviction is only issued when every slot is in use.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_evicted) |-> is_full)
        else $error("eviction issued while a slot is still free");

    // The search never looks past the slots in use.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (CNT_W'(r_scan) < r_used))
        else $error("search index beyond slots in use");

    // A fill increments the count by exactly one.
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && !r_found && !is_full) |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("fill did not advance slot count");

endmodule : per_thread_lru_slot_table_core

`default_nettype wire

// ===== sim/lru_slot_checker.sv =====
// Checker for the per-thread LRU slot table: predicts each slot grant and compares responses.

module lru_slot_checker #(
    parameter int SLOTS = ptlru_pkg::SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    input  wire logic                           i_req_ready,
    input  wire logic [ptlru_pkg::ID_W-1:0]     i_requester_id,
    input  wire logic                           i_rsp_valid,
    input  wire logic                           i_rsp_ready,
    input  wire logic [ptlru_pkg::IDX_W-1:0]    i_slot_index,
    input  wire logic                           i_hit,
    input  wire logic                           i_evicted,
    output int                                  o_fail_count,
    output int                                  o_pending_count
);

    // One predicted response transaction.
    typedef struct packed {
        logic [ptlru_pkg::IDX_W-1:0] index;
        logic                        hit;
        logic                        evicted;
    } slot_grant_t;

    // Predicted table contents: owner per slot and slots ordered from most
    // to least recently used.
    ptlru_pkg::t_id owner_of [SLOTS];
    int unsigned    mru_list [SLOTS];
    int unsigned    slots_used = 0;

    slot_grant_t pending_grants [$];
    slot_grant_t predicted;
    slot_grant_t wanted;
    int          fail_count = 0;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    // Move the slot at recency position pos to the front, shifting the
    // more recent ones back by one place.
    task automatic move_to_front(input int unsigned pos);
        int unsigned moved;
        moved = mru_list[pos];
        for (int k = pos; k > 0; k--) begin
            mru_list[k] = mru_list[k-1];
        end
        mru_list[0] = moved;
    endtask

    // Work out which slot a requester ends up with, and update the table.
    task automatic claim_slot(input ptlru_pkg::t_id id, output slot_grant_t grant);
        int unsigned pos;
        int unsigned slot;
        logic        found;
        pos   = 0;
        slot  = 0;
        found = 1'b0;
        while (pos < slots_used && !found) begin
            if (owner_of[mru_list[pos]] == id) begin
                found = 1'b1;
                slot  = mru_list[pos];
            end else begin
                pos++;
            end
        end
        grant.hit     = found;
        grant.evicted = 1'b0;
        if (found) begin
            move_to_front(pos);
        end else if (slots_used < SLOTS) begin
            // A never-used slot is still free: take the next one in index order.
            slot                 = slots_used;
            owner_of[slot]       = id;
            mru_list[slots_used] = slot;
            move_to_front(slots_used);
            slots_used++;
        end else begin
            // Table full: the least recently used slot changes owner.
            slot           = mru_list[SLOTS-1];
            owner_of[slot] = id;
            grant.evicted  = 1'b1;
            move_to_front(SLOTS - 1);
        end
        grant.index = slot[ptlru_pkg::IDX_W-1:0];
    endtask

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slots_used = 0;
            pending_grants.delete();
        end else begin
            // Response transaction: compare with the oldest prediction.
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_grants.size() == 0) begin
                    fail_count++;
                    $display("%0t: response with none expected: slot %0d hit %0b evicted %0b",
                             $time, i_slot_index, i_hit, i_evicted);
                end else begin
                    wanted = pending_grants.pop_front();
                    if (i_slot_index !== wanted.index) begin
                        fail_count++;
                        $display("%0t: slot_index expected %0d, got %0d",
                                 $time, wanted.index, i_slot_index);
                    end
                    if (i_hit !== wanted.hit) begin
                        fail_count++;
                        $display("%0t: hit expected %0b, got %0b", $time, wanted.hit, i_hit);
                    end
                    if (i_evicted !== wanted.evicted) begin
                        fail_count++;
                        $display("%0t: evicted expected %0b, got %0b",
                                 $time, wanted.evicted, i_evicted);
                    end
                end
            end
            // Request transaction: predict its response.
            if (i_req_valid && i_req_ready) begin
                claim_slot(i_requester_id, predicted);
                pending_grants.push_back(predicted);
            end
        end
        o_fail_count    <= fail_count;
        o_pending_count <= pending_grants.size();
    end

endmodule : lru_slot_checker

// ===== sim/testbench.sv =====
// Top of the testbench for the per-thread LRU slot table: stimulus, flow control and verdict.

module testbench;

    import ptlru_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int DRAIN_CYCLES   = 4 * SLOTS + 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 225;

    // Directed ids: extremes, id zero twice in a row, a fill, hits at both ends and
    // in the middle, and evictions once the table is full.
    localparam t_id DIRECTED_IDS [19] = '{
        31'h0000_0000, 31'h0000_0000, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555,
        31'h1, 31'h2, 31'h3, 31'h4, 31'h5, 31'h6,
        31'h0000_0000, 31'h7, 31'h7FFF_FFFF, 31'h3, 31'h7FFF_FFFF,
        31'h0000_0000, 31'h2AAA_AAAA, 31'h5555_5555
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    t_id                requester_id = '0;
    logic               rsp_ready    = 1'b0;
    logic               req_ready;
    logic               rsp_valid;
    logic [IDX_W-1:0]   slot_index;
    logic               hit;
    logic               evicted;

    int  fail_count;
    int  pending_count;
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    int  idle_cycles        = 0;
    t_id id_pool [32];
    int  pool_size;
    t_id last_id = '0;

    per_thread_lru_slot_table_core #(.SLOTS(SLOTS)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .o_req_ready    (req_ready),
        .i_requester_id (requester_id),
        .o_rsp_valid    (rsp_valid),
        .i_rsp_ready    (rsp_ready),
        .o_slot_index   (slot_index),
        .o_hit          (hit),
        .o_evicted      (evicted)
    );

    lru_slot_checker #(.SLOTS(SLOTS)) checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_requester_id  (requester_id),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_ready     (rsp_ready),
        .i_slot_index    (slot_index),
        .i_hit           (hit),
        .i_evicted       (evicted),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk) begin
        rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end

    // Give up when nothing has been accepted for too long.
    always @(posedge clk) begin
        if (rst_n && !(req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one request transaction, starting and ending at a falling edge.
    task automatic send_request(input t_id id);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        requester_id <= id;
        last_id      = id;
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Random requests: mostly ids from a small pool so that hits and
    // evictions both occur, some repeats of the last id and some fresh ids.
    task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
        t_id id;
        int  pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        pool_size          = $urandom_range(24, 6);
        for (int k = 0; k < pool_size; k++) begin
            id_pool[k] = t_id'($urandom);
        end
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                id = id_pool[$urandom_range(pool_size - 1, 0)];
            end else if (pick < 85) begin
                id = last_id;
            end else begin
                id = t_id'($urandom);
            end
            send_request(id);
        end
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_IDS[k]) begin
            send_request(DIRECTED_IDS[k]);
        end

        random_phase(0, 0, PHASE_ITEMS);
        random_phase(61, 0, PHASE_ITEMS);
        random_phase(0, 61, PHASE_ITEMS);
        random_phase(38, 38, PHASE_ITEMS);
        req_valid <= 1'b0;

        // Let every outstanding response arrive, then allow for stragglers.
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule : testbench

// ===== filelist.f =====
sv/ptlru_pkg.sv
sv/ptlru_ram.sv
sv/per_thread_lru_slot_table_core.sv
sim/lru_slot_checker.sv
sim/testbench.sv
